FILE: rtl/complex_fixed_point_alu_top_defines.svh
`ifndef COMPLEX_FIXED_POINT_ALU_TOP_DEFINES_SVH
`define COMPLEX_FIXED_POINT_ALU_TOP_DEFINES_SVH

// same-cycle implication
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfa assertion failed");

// next-cycle implication
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfa assertion failed");

`endif

FILE: rtl/cfa_pkg.sv
package cfa_pkg;

  localparam int DATA_WIDTH   = 16;
  localparam int FRAC_BITS    = 8;
  localparam int CORDIC_STEPS = 14;
  localparam int OP_W         = 3;
  localparam int ST_W         = 2;
  localparam int ANG_FRAC     = 24;
  localparam int ANG_TAB_LEN  = 24;
  localparam int ANG_W        = 32;
  localparam int CORDIC_W     = 64;
  localparam int CORDIC_SCALE = 61;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_MUL   = 3'd2,
    OP_DIV   = 3'd3,
    OP_CONJ  = 3'd4,
    OP_MAG   = 3'd5,
    OP_PHASE = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_DIVZ  = 2'd1,
    ST_SAT   = 2'd2,
    ST_PZERO = 2'd3
  } status_e;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ANG_W-1:0] ang_lookup(input int idx);
    logic signed [ANG_W-1:0] a;
    unique case (idx)
      0:  a = 32'sd754974720;
      1:  a = 32'sd445687602;
      2:  a = 32'sd235489088;
      3:  a = 32'sd119537938;
      4:  a = 32'sd60000934;
      5:  a = 32'sd30029717;
      6:  a = 32'sd15018523;
      7:  a = 32'sd7509720;
      8:  a = 32'sd3754917;
      9:  a = 32'sd1877466;
      10: a = 32'sd938734;
      11: a = 32'sd469367;
      12: a = 32'sd234684;
      13: a = 32'sd117342;
      14: a = 32'sd58671;
      15: a = 32'sd29335;
      16: a = 32'sd14668;
      17: a = 32'sd7334;
      18: a = 32'sd3667;
      19: a = 32'sd1833;
      20: a = 32'sd917;
      21: a = 32'sd458;
      22: a = 32'sd229;
      23: a = 32'sd115;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: rtl/cfa_in_if.sv
interface cfa_in_if #(
  parameter int DW = cfa_pkg::DATA_WIDTH
);
  logic                       valid;
  logic                       ready;
  logic [cfa_pkg::OP_W-1:0]   operation;
  logic signed [DW-1:0]       a_real;
  logic signed [DW-1:0]       a_imag;
  logic signed [DW-1:0]       b_real;
  logic signed [DW-1:0]       b_imag;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

FILE: rtl/cfa_out_if.sv
interface cfa_out_if #(
  parameter int DW = cfa_pkg::DATA_WIDTH
);
  logic                       valid;
  logic                       ready;
  logic signed [DW-1:0]       res_real;
  logic signed [DW-1:0]       res_imag;
  logic [cfa_pkg::ST_W-1:0]   status;

  modport source (output valid, res_real, res_imag, status, input ready);
  modport sink   (input valid, res_real, res_imag, status, output ready);
endinterface

FILE: rtl/cfa_div_pipe.sv
module cfa_div_pipe #(
  parameter int DW     = cfa_pkg::DATA_WIDTH,
  parameter int F      = cfa_pkg::FRAC_BITS,
  parameter int STAGES = 2 * cfa_pkg::DATA_WIDTH + 1 + cfa_pkg::FRAC_BITS
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*DW:0]     num_re_i,
  input  logic [2*DW:0]     num_im_i,
  input  logic [2*DW:0]     den_i,
  output logic [DW:0]       q_re_o,
  output logic              ovf_re_o,
  output logic [DW:0]       q_im_o,
  output logic              ovf_im_o
);

  localparam int PW    = 2 * DW;
  localparam int NW    = PW + 1 + F;
  localparam int QW    = DW + 1;
  localparam int NSTEP = NW;

  typedef struct packed {
    logic [NW-1:0] n;
    logic [PW:0]   r;
    logic [QW-1:0] q;
    logic          ovf;
  } lane_t;

  typedef struct packed {
    lane_t       re;
    lane_t       im;
    logic [PW:0] den;
  } st_t;

  st_t st_q  [STAGES];
  st_t st_in [STAGES];
  st_t st_d  [STAGES];

  function automatic lane_t step(input lane_t l, input logic [PW:0] den);
    logic [PW+1:0] r2;
    logic          ge;
    lane_t         o;
    r2    = {l.r, l.n[NW-1]};
    ge    = (r2 >= {1'b0, den});
    o.r   = (PW+1)'(ge ? r2 - {1'b0, den} : r2);
    o.n   = l.n << 1;
    o.q   = {l.q[QW-2:0], ge};
    o.ovf = l.ovf | l.q[QW-1];
    return o;
  endfunction

  always_comb begin
    st_in[0].re.n   = NW'(num_re_i) << F;
    st_in[0].re.r   = '0;
    st_in[0].re.q   = '0;
    st_in[0].re.ovf = 1'b0;
    st_in[0].im.n   = NW'(num_im_i) << F;
    st_in[0].im.r   = '0;
    st_in[0].im.q   = '0;
    st_in[0].im.ovf = 1'b0;
    st_in[0].den    = den_i;
    for (int k = 1; k < STAGES; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      st_d[k] = st_in[k];
      if (k < NSTEP) begin
        st_d[k].re = step(st_in[k].re, st_in[k].den);
        st_d[k].im = step(st_in[k].im, st_in[k].den);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign q_re_o   = st_q[STAGES-1].re.q;
  assign ovf_re_o = st_q[STAGES-1].re.ovf;
  assign q_im_o   = st_q[STAGES-1].im.q;
  assign ovf_im_o = st_q[STAGES-1].im.ovf;

endmodule

FILE: rtl/cfa_sqrt_pipe.sv
module cfa_sqrt_pipe #(
  parameter int DW     = cfa_pkg::DATA_WIDTH,
  parameter int STAGES = cfa_pkg::DATA_WIDTH
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [2*DW-1:0]   m_i,
  output logic [DW-1:0]     root_o
);

  localparam int PW    = 2 * DW;
  localparam int NSTEP = DW;

  typedef struct packed {
    logic [PW-1:0] m;
    logic [DW+1:0] rem;
    logic [DW-1:0] root;
  } st_t;

  st_t st_q  [STAGES];
  st_t st_in [STAGES];
  st_t st_d  [STAGES];

  function automatic st_t step(input st_t s);
    logic [DW+1:0] rem2;
    logic [DW+1:0] trial;
    logic          ge;
    st_t           o;
    rem2   = {s.rem[DW-1:0], s.m[PW-1:PW-2]};
    trial  = {s.root, 2'b01};
    ge     = (rem2 >= trial);
    o.rem  = ge ? rem2 - trial : rem2;
    o.root = {s.root[DW-2:0], ge};
    o.m    = s.m << 2;
    return o;
  endfunction

  always_comb begin
    st_in[0].m    = m_i;
    st_in[0].rem  = '0;
    st_in[0].root = '0;
    for (int k = 1; k < STAGES; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      st_d[k] = (k < NSTEP) ? step(st_in[k]) : st_in[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign root_o = st_q[STAGES-1].root;

endmodule

FILE: rtl/cfa_cordic_pipe.sv
module cfa_cordic_pipe #(
  parameter int STEPS  = cfa_pkg::CORDIC_STEPS,
  parameter int STAGES = cfa_pkg::CORDIC_STEPS
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [cfa_pkg::CORDIC_W-1:0]  x_i,
  input  logic signed [cfa_pkg::CORDIC_W-1:0]  y_i,
  output logic signed [cfa_pkg::ANG_W-1:0]     z_o
);

  localparam int CW = cfa_pkg::CORDIC_W;
  localparam int ZW = cfa_pkg::ANG_W;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } st_t;

  st_t st_q  [STAGES];
  st_t st_in [STAGES];
  st_t st_d  [STAGES];

  always_comb begin
    st_in[0].x = x_i;
    st_in[0].y = y_i;
    st_in[0].z = '0;
    for (int k = 1; k < STAGES; k++) begin
      st_in[k] = st_q[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      st_d[k] = st_in[k];
      if (k < STEPS) begin
        if (!st_in[k].y[CW-1]) begin
          st_d[k].x = st_in[k].x + (st_in[k].y >>> k);
          st_d[k].y = st_in[k].y - (st_in[k].x >>> k);
          st_d[k].z = st_in[k].z + cfa_pkg::ang_lookup(k);
        end else begin
          st_d[k].x = st_in[k].x - (st_in[k].y >>> k);
          st_d[k].y = st_in[k].y + (st_in[k].x >>> k);
          st_d[k].z = st_in[k].z - cfa_pkg::ang_lookup(k);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign z_o = st_q[STAGES-1].z;

endmodule

FILE: rtl/complex_fixed_point_alu_top.sv
// channel  dir  handshake      payload
// in_i     in   valid/ready    operation, a_real, a_imag, b_real, b_imag
// out_o    out  valid/ready    res_real, res_imag, status
//
// one word accepted per cycle while out_o is not stalled, every operation has the same latency
// a word passes the a and b registers, then the divider, square-root and CORDIC pipes, all as
// deep as the longest of them (the bit-per-stage divider at the default widths), then the output register
// rst_ni clears all valid bits asynchronously, datapath registers are not reset
// while out_o holds a word that is not taken, the whole pipeline freezes and
// in_i.ready stays low
`include "complex_fixed_point_alu_top_defines.svh"

module complex_fixed_point_alu_top #(
  parameter int DATA_WIDTH   = cfa_pkg::DATA_WIDTH,
  parameter int FRAC_BITS    = cfa_pkg::FRAC_BITS,
  parameter int CORDIC_STEPS = cfa_pkg::CORDIC_STEPS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cfa_in_if.sink    in_i,
  cfa_out_if.source out_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * DW;
  localparam int NW  = PW + 1 + F;
  localparam int QW  = DW + 1;
  localparam int CW  = cfa_pkg::CORDIC_W;
  localparam int ZW  = cfa_pkg::ANG_W;
  localparam int CS  = (CORDIC_STEPS < cfa_pkg::ANG_TAB_LEN) ? CORDIC_STEPS
                                                             : cfa_pkg::ANG_TAB_LEN;
  localparam int L0  = (NW > DW) ? NW : DW;
  localparam int L   = (L0 > CS) ? L0 : CS;
  localparam int SW  = (PW + 1 > ZW) ? PW + 1 : ZW;
  localparam int RSH = (cfa_pkg::ANG_FRAC > F) ? cfa_pkg::ANG_FRAC - F : 0;
  localparam int CSH = cfa_pkg::CORDIC_SCALE - DW;

  localparam logic signed [SW-1:0] SMAX_W = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN_W = ~SMAX_W;
  localparam logic signed [ZW-1:0] RND    =
    (RSH > 0) ? (ZW'(1) << ((RSH > 0) ? RSH - 1 : 0)) : '0;

  typedef struct packed {
    cfa_pkg::op_e         op;
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] br;
    logic signed [DW-1:0] bi;
    logic signed [PW-1:0] rr;
    logic signed [PW-1:0] ii;
    logic signed [PW-1:0] ri;
    logic signed [PW-1:0] ir;
    logic signed [PW-1:0] aa;
    logic signed [PW-1:0] ai2;
    logic signed [PW-1:0] bb;
    logic signed [PW-1:0] bi2;
  } a_t;

  typedef struct packed {
    cfa_pkg::op_e         op;
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 sat;
    logic                 divz;
    logic                 pzero;
    logic                 dneg_re;
    logic                 dneg_im;
  } side_t;

  function automatic logic [DW:0] sat_w(input logic signed [SW-1:0] v);
    logic [DW:0] r;
    if (v > SMAX_W) begin
      r = {1'b1, SMAX_W[DW-1:0]};
    end else if (v < SMIN_W) begin
      r = {1'b1, SMIN_W[DW-1:0]};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

  // truncate toward zero by the fraction bits
  function automatic logic signed [PW:0] trunc_f(input logic signed [PW:0] s);
    logic [PW:0]        m;
    logic [PW:0]        t;
    logic signed [PW:0] r;
    m = s[PW] ? -s : s;
    t = m >> F;
    r = $signed(t);
    if (s[PW]) r = -r;
    return r;
  endfunction

  function automatic logic [DW:0] sat_q(input logic neg, input logic [QW-1:0] q,
                                        input logic ovf);
    logic signed [SW-1:0] v;
    logic [DW:0]          r;
    v = SW'({1'b0, q});
    if (neg) v = -v;
    if (ovf) begin
      r = {1'b1, neg ? SMIN_W[DW-1:0] : SMAX_W[DW-1:0]};
    end else begin
      r = sat_w(v);
    end
    return r;
  endfunction

  logic adv;

  a_t   a_d, a_q;
  logic a_vld_q;

  side_t             b_side_d, b_side_q;
  logic              b_vld_q;
  logic [PW:0]       b_num_re_d, b_num_re_q;
  logic [PW:0]       b_num_im_d, b_num_im_q;
  logic [PW:0]       b_den_d, b_den_q;
  logic [PW-1:0]     b_m_d, b_m_q;
  logic signed [CW-1:0] b_x_d, b_x_q;
  logic signed [CW-1:0] b_y_d, b_y_q;

  side_t      side_q [L];
  logic [L-1:0] vld_q;

  logic [QW-1:0]        q_re, q_im;
  logic                 ovf_re, ovf_im;
  logic [DW-1:0]        root;
  logic signed [ZW-1:0] z;

  logic signed [DW-1:0] out_re_d, out_re_q;
  logic signed [DW-1:0] out_im_d, out_im_q;
  cfa_pkg::status_e     out_st_d, out_st_q;
  cfa_pkg::op_e         out_op_q;
  logic                 out_vld_q;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  always_comb begin
    a_d.op  = cfa_pkg::op_e'(in_i.operation);
    a_d.ar  = in_i.a_real;
    a_d.ai  = in_i.a_imag;
    a_d.br  = in_i.b_real;
    a_d.bi  = in_i.b_imag;
    a_d.rr  = PW'(in_i.a_real) * PW'(in_i.b_real);
    a_d.ii  = PW'(in_i.a_imag) * PW'(in_i.b_imag);
    a_d.ri  = PW'(in_i.a_real) * PW'(in_i.b_imag);
    a_d.ir  = PW'(in_i.a_imag) * PW'(in_i.b_real);
    a_d.aa  = PW'(in_i.a_real) * PW'(in_i.a_real);
    a_d.ai2 = PW'(in_i.a_imag) * PW'(in_i.a_imag);
    a_d.bb  = PW'(in_i.b_real) * PW'(in_i.b_real);
    a_d.bi2 = PW'(in_i.b_imag) * PW'(in_i.b_imag);
  end

  logic [DW:0]          add_re, add_im, sub_re, sub_im, mul_re, mul_im, cnj_im;
  logic signed [PW:0]   s_mre, s_mim, n_re, n_im;
  logic signed [CW-1:0] xe, ye;

  always_comb begin
    add_re = sat_w(SW'(a_q.ar) + SW'(a_q.br));
    add_im = sat_w(SW'(a_q.ai) + SW'(a_q.bi));
    sub_re = sat_w(SW'(a_q.ar) - SW'(a_q.br));
    sub_im = sat_w(SW'(a_q.ai) - SW'(a_q.bi));
    cnj_im = sat_w(-SW'(a_q.ai));
    s_mre  = (PW+1)'(a_q.rr) - (PW+1)'(a_q.ii);
    s_mim  = (PW+1)'(a_q.ri) + (PW+1)'(a_q.ir);
    mul_re = sat_w(SW'(trunc_f(s_mre)));
    mul_im = sat_w(SW'(trunc_f(s_mim)));

    b_side_d.op = a_q.op;
    unique case (a_q.op)
      cfa_pkg::OP_ADD: begin
        b_side_d.re  = add_re[DW-1:0];
        b_side_d.im  = add_im[DW-1:0];
        b_side_d.sat = add_re[DW] | add_im[DW];
      end
      cfa_pkg::OP_SUB: begin
        b_side_d.re  = sub_re[DW-1:0];
        b_side_d.im  = sub_im[DW-1:0];
        b_side_d.sat = sub_re[DW] | sub_im[DW];
      end
      cfa_pkg::OP_MUL: begin
        b_side_d.re  = mul_re[DW-1:0];
        b_side_d.im  = mul_im[DW-1:0];
        b_side_d.sat = mul_re[DW] | mul_im[DW];
      end
      cfa_pkg::OP_CONJ: begin
        b_side_d.re  = a_q.ar;
        b_side_d.im  = cnj_im[DW-1:0];
        b_side_d.sat = cnj_im[DW];
      end
      default: begin
        b_side_d.re  = '0;
        b_side_d.im  = '0;
        b_side_d.sat = 1'b0;
      end
    endcase

    n_re = (PW+1)'(a_q.rr) + (PW+1)'(a_q.ii);
    n_im = (PW+1)'(a_q.ir) - (PW+1)'(a_q.ri);
    b_side_d.dneg_re = n_re[PW];
    b_side_d.dneg_im = n_im[PW];
    b_num_re_d = n_re[PW] ? -n_re : n_re;
    b_num_im_d = n_im[PW] ? -n_im : n_im;
    b_den_d    = (PW+1)'($unsigned(a_q.bb)) + (PW+1)'($unsigned(a_q.bi2));
    b_side_d.divz  = (a_q.br == '0) && (a_q.bi == '0);

    b_m_d = $unsigned(a_q.aa) + $unsigned(a_q.ai2);

    // fold the left half plane onto the right one
    xe = a_q.ar[DW-1] ? -CW'(a_q.ar) : CW'(a_q.ar);
    ye = a_q.ar[DW-1] ? -CW'(a_q.ai) : CW'(a_q.ai);
    b_x_d = xe <<< CSH;
    b_y_d = ye <<< CSH;
    b_side_d.pzero = (a_q.ar == '0) && (a_q.ai == '0);
  end

  cfa_div_pipe #(
    .DW     (DW),
    .F      (F),
    .STAGES (L)
  ) u_div (
    .clk_i    (clk_i),
    .en_i     (adv),
    .num_re_i (b_num_re_q),
    .num_im_i (b_num_im_q),
    .den_i    (b_den_q),
    .q_re_o   (q_re),
    .ovf_re_o (ovf_re),
    .q_im_o   (q_im),
    .ovf_im_o (ovf_im)
  );

  cfa_sqrt_pipe #(
    .DW     (DW),
    .STAGES (L)
  ) u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .m_i    (b_m_q),
    .root_o (root)
  );

  cfa_cordic_pipe #(
    .STEPS  (CS),
    .STAGES (L)
  ) u_cordic (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (b_x_q),
    .y_i   (b_y_q),
    .z_o   (z)
  );

  side_t                s;
  logic [DW:0]          dv_re, dv_im, rt, ph;
  logic signed [ZW-1:0] zr;

  always_comb begin
    s     = side_q[L-1];
    dv_re = sat_q(s.dneg_re, q_re, ovf_re);
    dv_im = sat_q(s.dneg_im, q_im, ovf_im);
    rt    = sat_w(SW'({1'b0, root}));
    zr    = (z + RND) >>> RSH;
    ph    = sat_w(SW'(zr));

    out_re_d = '0;
    out_im_d = '0;
    out_st_d = cfa_pkg::ST_OK;
    unique case (s.op)
      cfa_pkg::OP_ADD, cfa_pkg::OP_SUB, cfa_pkg::OP_MUL, cfa_pkg::OP_CONJ: begin
        out_re_d = s.re;
        out_im_d = s.im;
        out_st_d = s.sat ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
      end
      cfa_pkg::OP_DIV: begin
        if (s.divz) begin
          out_st_d = cfa_pkg::ST_DIVZ;
        end else begin
          out_re_d = dv_re[DW-1:0];
          out_im_d = dv_im[DW-1:0];
          out_st_d = (dv_re[DW] | dv_im[DW]) ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
        end
      end
      cfa_pkg::OP_MAG: begin
        out_re_d = rt[DW-1:0];
        out_st_d = rt[DW] ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
      end
      cfa_pkg::OP_PHASE: begin
        if (s.pzero) begin
          out_st_d = cfa_pkg::ST_PZERO;
        end else begin
          out_re_d = ph[DW-1:0];
          out_st_d = ph[DW] ? cfa_pkg::ST_SAT : cfa_pkg::ST_OK;
        end
      end
      default: begin
        out_st_d = cfa_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= in_i.valid;
      b_vld_q   <= a_vld_q;
      vld_q     <= {vld_q[L-2:0], b_vld_q};
      out_vld_q <= vld_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q        <= a_d;
      b_side_q   <= b_side_d;
      b_num_re_q <= b_num_re_d;
      b_num_im_q <= b_num_im_d;
      b_den_q    <= b_den_d;
      b_m_q      <= b_m_d;
      b_x_q      <= b_x_d;
      b_y_q      <= b_y_d;
      side_q[0]  <= b_side_q;
      for (int k = 1; k < L; k++) begin
        side_q[k] <= side_q[k-1];
      end
      out_re_q <= out_re_d;
      out_im_q <= out_im_d;
      out_st_q <= out_st_d;
      out_op_q <= s.op;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.res_real = out_re_q;
  assign out_o.res_imag = out_im_q;
  assign out_o.status   = out_st_q;

  `CFA_ASSERT_IMP(a_divz_only_div, clk_i, rst_ni, out_vld_q && out_st_q == cfa_pkg::ST_DIVZ, out_op_q == cfa_pkg::OP_DIV)
  `CFA_ASSERT_IMP(a_pzero_only_phase, clk_i, rst_ni, out_vld_q && out_st_q == cfa_pkg::ST_PZERO, out_op_q == cfa_pkg::OP_PHASE)
  `CFA_ASSERT_IMP(a_scalar_imag_zero, clk_i, rst_ni, out_vld_q && (out_op_q == cfa_pkg::OP_MAG || out_op_q == cfa_pkg::OP_PHASE), out_im_q == '0)
  `CFA_ASSERT_NXT(a_stall_freeze, clk_i, rst_ni, !adv, $stable(vld_q) && $stable(a_vld_q) && $stable(b_vld_q))

endmodule
